>>> rtl/core/tlts_pkg.sv
// ----------------------------------------------------------------------------
// tlts_pkg
// shared constants and codes for the two-list time-slice scheduler
// ----------------------------------------------------------------------------
package tlts_pkg;
    localparam int MAX_TASKS     = 64;
    localparam int PRIORITY_BITS = 8;
    localparam int ID_W          = 6;
    localparam int PRI_IN_W      = 8;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_ADD  = 2'd1,
        FUNC_SET  = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_RUN = 1'b1;
endpackage

>>> rtl/core/two_list_time_slice_scheduler.sv
// ----------------------------------------------------------------------------
// two_list_time_slice_scheduler
// task scheduler with two linked task lists, an active-list flag and a
// time-slice counter; one sequencer walks the link memories step by step
// ----------------------------------------------------------------------------
// An add item raises busy while the task is appended, first taking it off its
// list when it is on one; status and unknown items are taken at the accepting
// edge and never raise busy. A tick that reselects moves any current task to
// the inactive list, then walks the active list, and possibly the other list,
// one link memory read at a time. busy is high while an item is at work. Each
// tick gives one result on o_run_task / o_status with o_valid high for one
// cycle; the receiver cannot stall, and no other item yields a result.
module two_list_time_slice_scheduler #(
    parameter int MAX_TASKS     = tlts_pkg::MAX_TASKS,
    parameter int PRIORITY_BITS = tlts_pkg::PRIORITY_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_func,
    input  logic [tlts_pkg::ID_W-1:0] i_task_id,
    input  logic [tlts_pkg::PRI_IN_W-1:0] i_priority_req,
    input  logic                      i_runnable,
    output logic                      o_valid,
    output logic [tlts_pkg::ID_W-1:0] o_run_task,
    output logic                      o_status
);
    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int SW = PRIORITY_BITS + 1;
    localparam int CW = TW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_UNLINK_RD, S_UNLINK_WAIT, S_UNLINK_FIX, S_APPEND,
        S_APPEND_TICK, S_WALK_INIT, S_WALK_RD, S_WALK_CHK, S_SEL_RD,
        S_SEL_WAIT, S_DONE
    } t_state;

    // link and priority memories
    logic [TW-1:0]            r_next [MAX_TASKS];
    logic [TW-1:0]            r_prev [MAX_TASKS];
    logic [PRIORITY_BITS-1:0] r_pri  [MAX_TASKS];
    logic [MAX_TASKS-1:0]     r_run;
    logic [1:0]               r_member [MAX_TASKS];

    logic [TW-1:0] r_head [2];
    logic [TW-1:0] r_tail [2];
    logic [1:0]    r_nonempty;

    t_state        r_state;
    logic          r_busy, r_valid, r_status;
    logic [TW-1:0] r_out_task;
    logic          r_cur_valid;
    logic [TW-1:0] r_cur;
    logic [SW-1:0] r_slice;
    logic          r_active;
    logic          r_swapped;

    logic [1:0]    r_func;
    logic [TW-1:0] r_id;
    logic [PRIORITY_BITS-1:0] r_pri_in;
    logic          r_run_in;
    logic          r_list;
    logic [TW-1:0] r_walk;
    logic [CW-1:0] r_steps;
    logic [TW-1:0] r_rd_next, r_rd_prev;
    logic [PRIORITY_BITS-1:0] r_rd_pri;

    logic id_ok;
    assign id_ok = (32'(i_task_id) < 32'(MAX_TASKS));

    assign busy       = r_busy;
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_run_task = tlts_pkg::ID_W'(r_out_task);

    // registered memory reads at the sequencer address
    always_ff @(posedge i_clk) begin
        r_rd_next <= r_next[(r_state == S_WALK_RD) ? r_walk : r_id];
        r_rd_prev <= r_prev[r_id];
        r_rd_pri  <= r_pri[r_walk];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_valid     <= 1'b0;
            r_status    <= tlts_pkg::STATUS_OK;
            r_out_task  <= '0;
            r_run       <= '0;
            r_nonempty  <= '0;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_slice     <= '0;
            r_active    <= 1'b0;
            for (int k = 0; k < MAX_TASKS; k++) r_member[k] <= 2'd0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func   <= i_func;
                        r_pri_in <= PRIORITY_BITS'(i_priority_req);
                        r_run_in <= i_runnable;
                        if (i_func == tlts_pkg::FUNC_TICK) begin
                            r_busy <= 1'b1;
                            if (r_slice == '0 || !r_cur_valid || !r_run[r_cur]) begin
                                r_slice <= '0;
                                r_id    <= r_cur;
                                r_list  <= ~r_active;
                                r_state <= r_cur_valid ? S_UNLINK_RD : S_WALK_INIT;
                            end else begin
                                r_state <= S_DEC;
                            end
                        end else begin
                            r_id   <= TW'(i_task_id);
                            r_list <= 1'b0;
                            if (i_func == tlts_pkg::FUNC_ADD && id_ok) begin
                                r_busy  <= 1'b1;
                                r_state <= S_UNLINK_RD;
                            end else if (i_func == tlts_pkg::FUNC_SET && id_ok) begin
                                r_run[TW'(i_task_id)] <= i_runnable;
                            end
                        end
                    end
                end
                S_DEC: begin
                    r_slice    <= r_slice - 1'b1;
                    r_out_task <= r_cur;
                    r_status   <= tlts_pkg::STATUS_OK;
                    r_valid    <= 1'b1;
                    r_state    <= S_DONE;
                end
                S_UNLINK_RD: begin
                    r_state <= (r_member[r_id] == 2'd0) ? S_APPEND : S_UNLINK_WAIT;
                end
                S_UNLINK_WAIT: r_state <= S_UNLINK_FIX;
                S_UNLINK_FIX: begin
                    logic l, ah, at;
                    l  = ~r_member[r_id][0];
                    ah = (r_head[l] == r_id);
                    at = (r_tail[l] == r_id);
                    if (ah && at) begin
                        r_nonempty[l] <= 1'b0;
                    end else begin
                        if (ah) r_head[l] <= r_rd_next;
                        else r_next[r_rd_prev] <= r_rd_next;
                        if (at) r_tail[l] <= r_rd_prev;
                        else r_prev[r_rd_next] <= r_rd_prev;
                    end
                    r_member[r_id] <= 2'd0;
                    r_state <= S_APPEND;
                end
                S_APPEND: begin
                    if (!r_nonempty[r_list]) begin
                        r_head[r_list]     <= r_id;
                        r_nonempty[r_list] <= 1'b1;
                    end else begin
                        r_next[r_tail[r_list]] <= r_id;
                        r_prev[r_id]           <= r_tail[r_list];
                    end
                    r_tail[r_list]  <= r_id;
                    r_member[r_id]  <= {r_list, ~r_list};
                    if (r_func == tlts_pkg::FUNC_ADD) begin
                        r_pri[r_id] <= r_pri_in;
                        r_run[r_id] <= r_run_in;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_WALK_INIT;
                    end
                end
                S_WALK_INIT: begin
                    r_swapped <= 1'b0;
                    r_walk    <= r_head[r_active];
                    r_steps   <= '0;
                    r_state   <= r_nonempty[r_active] ? S_WALK_RD : S_WALK_CHK;
                end
                S_WALK_RD: r_state <= S_WALK_CHK;
                S_WALK_CHK: begin
                    // stop on found, tail, step limit or empty list
                    if (r_nonempty[r_active] && r_run[r_walk]) begin
                        r_state <= S_SEL_RD;
                    end else if (!r_nonempty[r_active] || r_walk == r_tail[r_active]
                                 || r_steps == CW'(MAX_TASKS - 1)) begin
                        if (!r_swapped) begin
                            r_active  <= ~r_active;
                            r_swapped <= 1'b1;
                            r_walk    <= r_head[~r_active];
                            r_steps   <= '0;
                            r_state   <= r_nonempty[~r_active] ? S_WALK_RD : S_WALK_CHK;
                        end else begin
                            r_cur_valid <= 1'b0;
                            r_cur       <= '0;
                            r_out_task  <= '0;
                            r_status    <= tlts_pkg::STATUS_NO_RUN;
                            r_valid     <= 1'b1;
                            r_state     <= S_DONE;
                        end
                    end else begin
                        r_walk  <= r_rd_next;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_WALK_RD;
                    end
                end
                S_SEL_RD: r_state <= S_SEL_WAIT;
                S_SEL_WAIT: begin
                    r_slice     <= (r_rd_pri != '0) ? SW'(r_rd_pri) - 1'b1 : '0;
                    r_cur       <= r_walk;
                    r_cur_valid <= 1'b1;
                    r_out_task  <= r_walk;
                    r_status    <= tlts_pkg::STATUS_OK;
                    r_valid     <= 1'b1;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
